@@ rtl/lge_pkg.sv @@
`default_nettype none
package lge_pkg;

	localparam int GRID_MAX_DEF = 64;

	// Fixed field widths of the ports.
	localparam int OP_W    = 2;
	localparam int COORD_W = 6;
	localparam int CFG_W   = 7;
	localparam int POP_W   = 13;
	localparam int NB_W    = 4;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
	localparam logic [OP_W-1:0] OP_READ    = 2'd1;
	localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;

	// B3/S23 neighbour counts.
	localparam logic [NB_W-1:0] BIRTH_CNT   = 4'd3;
	localparam logic [NB_W-1:0] SURVIVE_CNT = 4'd2;

	typedef struct packed {
		logic load_in;
		logic cfg_wr;
		logic sweep_clr;
		logic rd_sweep;
		logic adv;
		logic rd_op;
		logic commit;
	} cmd_t;

endpackage
`default_nettype wire

@@ rtl/lge_ctrl.sv @@
`default_nettype none
module lge_ctrl #(
	parameter int GRID_MAX = lge_pkg::GRID_MAX_DEF,
	localparam int N_W = $clog2(GRID_MAX + 1)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [lge_pkg::OP_W-1:0] op,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [N_W-1:0]           size,
	output lge_pkg::cmd_t                 cmd,
	output logic [N_W-1:0]                sweep_row
);
	import lge_pkg::*;

	localparam int K_W = $clog2(GRID_MAX + 3);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_COUNT = 5'b00010,
		S_ADV   = 5'b00100,
		S_OP_RD = 5'b01000,
		S_OP_WB = 5'b10000
	} state_t;

	state_t         state_q, state_d;
	logic [K_W-1:0] k_q;
	logic           dirty_q;
	logic           out_valid_q;
	logic           accept;
	logic           sweeping;
	logic           sweep_end;
	logic           out_free;

	assign accept    = in_valid && (state_q == S_IDLE);
	assign in_stall  = (state_q != S_IDLE);
	// A pending input transaction takes precedence, so a size change never lands on the
	// same edge as an accepted operation.
	assign cfg_ready = (state_q == S_IDLE) && !in_valid;
	assign sweeping  = (state_q == S_COUNT) || (state_q == S_ADV);
	// The sweep counter runs on to size + 2, past the last row, so the write-back and the count pipeline drain.
	assign sweep_end = (k_q == (K_W'(size) + K_W'(2)));
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign sweep_row = N_W'(k_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (op == OP_ADVANCE) begin
						state_d = S_ADV;
					end else if (dirty_q) begin
						state_d = S_COUNT;
					end else begin
						state_d = S_OP_RD;
					end
				end
			end
			S_COUNT, S_ADV: begin
				if (sweep_end) begin
					state_d = S_OP_RD;
				end
			end
			S_OP_RD: begin
				state_d = S_OP_WB;
			end
			S_OP_WB: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.load_in   = accept;
		cmd.cfg_wr    = cfg_valid && cfg_ready;
		cmd.sweep_clr = accept && ((op == OP_ADVANCE) || dirty_q);
		cmd.rd_sweep  = sweeping && (k_q <= K_W'(size));
		cmd.adv       = (state_q == S_ADV);
		cmd.rd_op     = (state_q == S_OP_RD);
		cmd.commit    = (state_q == S_OP_WB) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			dirty_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				k_q <= '0;
			end else if (sweeping) begin
				k_q <= k_q + K_W'(1);
			end
			// A new size invalidates the running population and border counts.
			if (cmd.cfg_wr) begin
				dirty_q <= 1'b1;
			end else if (sweeping && sweep_end) begin
				dirty_q <= 1'b0;
			end
			out_valid_q <= cmd.commit || (out_valid_q && out_stall);
		end
	end

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || !out_stall))
		else $error("result committed while the output register was occupied");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("committed result not presented");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q != S_IDLE))
		else $error("accepted transaction did not start work");

	a_counts_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OP_WB) |-> !dirty_q)
		else $error("result formed from stale counts");

	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sweeping |-> (k_q <= (K_W'(size) + K_W'(2))))
		else $error("sweep counter ran past its end");

endmodule
`default_nettype wire

@@ rtl/lge_datapath.sv @@
`default_nettype none
module lge_datapath #(
	parameter int GRID_MAX = lge_pkg::GRID_MAX_DEF,
	localparam int N_W = $clog2(GRID_MAX + 1)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire lge_pkg::cmd_t               cmd,
	input  wire logic [N_W-1:0]              sweep_row,
	input  wire logic [lge_pkg::OP_W-1:0]    op,
	input  wire logic [lge_pkg::COORD_W-1:0] row,
	input  wire logic [lge_pkg::COORD_W-1:0] col,
	input  wire logic                        cell_in,
	input  wire logic [lge_pkg::CFG_W-1:0]   cfg_data,
	output logic [N_W-1:0]                   size,
	output logic                             cell_out,
	output logic [lge_pkg::POP_W-1:0]        population,
	output logic                             edge_alive
);
	import lge_pkg::*;

	localparam int ROW_W = $clog2(GRID_MAX);
	localparam int SZ_W  = (N_W > CFG_W) ? N_W : CFG_W;
	localparam int LV    = $clog2(GRID_MAX);
	localparam int P     = 2 ** LV;
	localparam int BRD_W = $clog2(4 * GRID_MAX + 1);
	localparam int CC_W  = COORD_W + N_W;

	// Configuration and effective size.
	logic [SZ_W-1:0]     sz_q;
	logic [N_W-1:0]      n;
	logic [GRID_MAX-1:0] mask;

	// Captured transaction.
	logic [OP_W-1:0]    op_q;
	logic [COORD_W-1:0] row_q;
	logic [COORD_W-1:0] col_q;
	logic               cin_q;
	logic               in_grid;
	logic               on_border;
	logic [ROW_W-1:0]   row_addr;
	logic [ROW_W-1:0]   col_idx;

	// Row store; a row never written since reset reads as all dead.
	logic [GRID_MAX-1:0] mem [GRID_MAX];
	logic [GRID_MAX-1:0] row_vld_q;
	logic                rd_en;
	logic [ROW_W-1:0]    rd_addr;
	logic [GRID_MAX-1:0] rd_data_s1;
	logic                rd_live_s1;
	logic [GRID_MAX-1:0] rdata;
	logic                we;
	logic [ROW_W-1:0]    waddr;
	logic [GRID_MAX-1:0] wdata;
	logic [GRID_MAX-1:0] wdata_op;
	logic                we_op;
	logic                we_adv;

	// Sweep stage one.
	logic            sweep_s1;
	logic            adv_s1;
	logic [N_W-1:0]  row_s1;
	logic            beyond;
	logic [GRID_MAX-1:0] bot;
	logic [GRID_MAX-1:0] top_q;
	logic [GRID_MAX-1:0] mid_q;
	logic [GRID_MAX-1:0] mid_raw_q;
	logic [GRID_MAX-1:0] nxt;
	logic [GRID_MAX-1:0] new_row;
	logic [NB_W-1:0]     nb [GRID_MAX];
	logic [GRID_MAX-1:0] top_l, top_r, mid_l, mid_r, bot_l, bot_r;

	// Count stage two.
	logic                acc_s2;
	logic [GRID_MAX-1:0] bits_s2;
	logic [N_W-1:0]      idx_s2;
	logic [P-1:0]        bits_pad;
	logic [N_W-1:0]      tree [LV+1][P];
	logic [N_W-1:0]      pc;
	logic [N_W-1:0]      brd_inc;

	logic [POP_W-1:0] pop_q, pop_nx;
	logic [BRD_W-1:0] brd_q, brd_nx;
	logic             old_cell;

	always_comb begin
		if (sz_q == '0) begin
			n = N_W'(1);
		end else if (sz_q > SZ_W'(GRID_MAX)) begin
			n = N_W'(GRID_MAX);
		end else begin
			n = N_W'(sz_q);
		end
		for (int i = 0; i < GRID_MAX; i++) begin
			mask[i] = (N_W'(i) < n);
		end
	end
	assign size = n;

	assign in_grid   = (CC_W'(row_q) < CC_W'(n)) && (CC_W'(col_q) < CC_W'(n));
	assign on_border = (row_q == '0) || (col_q == '0) ||
		(CC_W'(row_q) == CC_W'(n) - CC_W'(1)) || (CC_W'(col_q) == CC_W'(n) - CC_W'(1));
	assign row_addr  = ROW_W'(row_q);
	assign col_idx   = ROW_W'(col_q);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q  <= op;
			row_q <= row;
			col_q <= col;
			cin_q <= cell_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sz_q <= SZ_W'(GRID_MAX);
		end else if (cmd.cfg_wr) begin
			sz_q <= SZ_W'(cfg_data);
		end
	end

	// Memory access.
	assign rd_en   = cmd.rd_sweep || cmd.rd_op;
	assign rd_addr = cmd.rd_op ? row_addr : ROW_W'(sweep_row);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			rd_live_s1 <= row_vld_q[rd_addr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (we) begin
			row_vld_q[waddr] <= 1'b1;
		end
	end

	assign rdata = rd_live_s1 ? rd_data_s1 : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_s1 <= 1'b0;
			adv_s1   <= 1'b0;
		end else begin
			sweep_s1 <= cmd.rd_sweep;
			adv_s1   <= cmd.adv;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_sweep) begin
			row_s1 <= sweep_row;
		end
	end

	// Rows at or past the active size act as dead neighbours.
	assign beyond = (row_s1 >= n);
	assign bot    = beyond ? '0 : (rdata & mask);

	always_ff @(posedge clk) begin
		if (cmd.sweep_clr) begin
			top_q     <= '0;
			mid_q     <= '0;
			mid_raw_q <= '0;
		end else if (sweep_s1 && adv_s1) begin
			top_q     <= mid_q;
			mid_q     <= bot;
			mid_raw_q <= beyond ? '0 : rdata;
		end
	end

	// Generation rule on the row held in mid_q, with the row below arriving from memory.
	assign top_l = top_q << 1;
	assign top_r = top_q >> 1;
	assign mid_l = mid_q << 1;
	assign mid_r = mid_q >> 1;
	assign bot_l = bot << 1;
	assign bot_r = bot >> 1;

	always_comb begin
		for (int c = 0; c < GRID_MAX; c++) begin
			nb[c] = NB_W'(top_l[c]) + NB_W'(top_q[c]) + NB_W'(top_r[c]) +
				NB_W'(mid_l[c]) + NB_W'(mid_r[c]) +
				NB_W'(bot_l[c]) + NB_W'(bot[c]) + NB_W'(bot_r[c]);
			nxt[c] = (nb[c] == BIRTH_CNT) || (mid_q[c] && (nb[c] == SURVIVE_CNT));
		end
	end

	// Columns outside the active grid keep what they hold.
	assign new_row = (nxt & mask) | (mid_raw_q & ~mask);

	assign we_adv = sweep_s1 && adv_s1 && (row_s1 != '0);
	assign we_op  = cmd.commit && (op_q == OP_WRITE) && in_grid;

	always_comb begin
		wdata_op = rdata;
		if (in_grid) begin
			wdata_op[col_idx] = cin_q;
		end
	end

	assign we    = we_adv || we_op;
	assign waddr = we_adv ? ROW_W'(row_s1 - N_W'(1)) : row_addr;
	assign wdata = we_adv ? new_row : wdata_op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s2 <= 1'b0;
		end else begin
			acc_s2 <= we_adv || (sweep_s1 && !adv_s1 && !beyond);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			bits_s2 <= new_row & mask;
			idx_s2  <= row_s1 - N_W'(1);
		end else begin
			bits_s2 <= bot;
			idx_s2  <= row_s1;
		end
	end

	// Population of one row through a balanced adder tree.
	always_comb begin
		bits_pad = P'(bits_s2);
		for (int l = 0; l <= LV; l++) begin
			for (int i = 0; i < P; i++) begin
				tree[l][i] = '0;
			end
		end
		for (int i = 0; i < P; i++) begin
			tree[0][i] = N_W'(bits_pad[i]);
		end
		for (int l = 0; l < LV; l++) begin
			for (int i = 0; i < (P >> (l + 1)); i++) begin
				tree[l+1][i] = tree[l][2*i] + tree[l][2*i+1];
			end
		end
		pc = tree[LV][0];
	end

	always_comb begin
		if ((idx_s2 == '0) || (idx_s2 == n - N_W'(1))) begin
			brd_inc = pc;
		end else begin
			brd_inc = N_W'(bits_s2[0]) + N_W'(bits_s2[ROW_W'(n - N_W'(1))]);
		end
	end

	assign old_cell = rdata[col_idx];

	always_comb begin
		pop_nx = pop_q;
		brd_nx = brd_q;
		if ((op_q == OP_WRITE) && in_grid && (old_cell != cin_q)) begin
			if (cin_q) begin
				pop_nx = pop_q + POP_W'(1);
				if (on_border) begin
					brd_nx = brd_q + BRD_W'(1);
				end
			end else begin
				pop_nx = pop_q - POP_W'(1);
				if (on_border) begin
					brd_nx = brd_q - BRD_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_q <= '0;
			brd_q <= '0;
		end else if (cmd.sweep_clr) begin
			pop_q <= '0;
			brd_q <= '0;
		end else if (acc_s2) begin
			pop_q <= pop_q + POP_W'(pc);
			brd_q <= brd_q + BRD_W'(brd_inc);
		end else if (cmd.commit) begin
			pop_q <= pop_nx;
			brd_q <= brd_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (!in_grid) begin
				cell_out <= 1'b0;
			end else if (op_q == OP_WRITE) begin
				cell_out <= cin_q;
			end else begin
				cell_out <= old_cell;
			end
			population <= pop_nx;
			edge_alive <= (brd_nx != '0);
		end
	end

endmodule
`default_nettype wire

@@ rtl/life_generation_engine.sv @@
`default_nettype none
// Conway Life engine (B3/S23) on a square grid of up to GRID_MAX by GRID_MAX cells, of which
// the top-left active_size by active_size cells are in use; the grid does not wrap. Each input
// transaction writes a cell, reads a cell or advances one generation, and yields one result:
// the cell at row,col, the live population and a flag for a live cell on the active border.
// The grid is held one row per memory word with a valid bit per row, so it reads as all dead
// straight after reset with no clearing pass. A write or read runs from acceptance through one
// memory read, then the read-modify-write that also updates the running population and border
// counts, which waits while the output register is held. An advance sweeps the rows through a
// three-row window, one row per cycle on the single read and write port. The first write or
// read after a change of active_size is preceded by a recount sweep.
module life_generation_engine #(
	parameter int GRID_MAX = lge_pkg::GRID_MAX_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [lge_pkg::OP_W-1:0]    op,
	input  wire logic [lge_pkg::COORD_W-1:0] row,
	input  wire logic [lge_pkg::COORD_W-1:0] col,
	input  wire logic                        cell_in,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             cell_out,
	output logic [lge_pkg::POP_W-1:0]        population,
	output logic                             edge_alive,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [lge_pkg::CFG_W-1:0]   cfg_data
);
	import lge_pkg::*;

	localparam int N_W = $clog2(GRID_MAX + 1);

	cmd_t           cmd;
	logic [N_W-1:0] size;
	logic [N_W-1:0] sweep_row;

	lge_ctrl #(
		.GRID_MAX(GRID_MAX)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.size     (size),
		.cmd      (cmd),
		.sweep_row(sweep_row)
	);

	lge_datapath #(
		.GRID_MAX(GRID_MAX)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sweep_row (sweep_row),
		.op        (op),
		.row       (row),
		.col       (col),
		.cell_in   (cell_in),
		.cfg_data  (cfg_data),
		.size      (size),
		.cell_out  (cell_out),
		.population(population),
		.edge_alive(edge_alive)
	);

endmodule
`default_nettype wire
